// File: design/u8dec_pkg.sv
// shared types and constants for the utf-8 stream decoder
`timescale 1ns / 1ps

package u8dec_pkg;

    localparam int CP_W    = 21;
    localparam int BYTE_W  = 8;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [CP_W-1:0]   t_code_point;
    typedef logic [1:0]        t_pend;
    typedef logic [2:0]        t_len;
    typedef logic [2:0]        t_res_count;

    localparam t_len LEN_NONE = 3'd0;
    localparam t_len LEN_TWO  = 3'd2;
    localparam t_len LEN_THREE = 3'd3;
    localparam t_len LEN_FOUR = 3'd4;

    localparam t_byte LEAD_ED = 8'hED;

endpackage

// File: design/utf8_stream_decoder.sv
// utf-8 stream decoder: one byte per transfer in, one code point or error per transfer out
// one input register feeds one result register; an accepted byte is decoded between them
// throughput: one byte per cycle while each byte yields at most one result and
//   the output does not stall; a byte that yields n results holds the result
//   register until all n are taken; each register is able to hold a transfer
// reset (synchronous, active low) closes any open sequence and empties both registers
`timescale 1ns / 1ps

module utf8_stream_decoder (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  u8dec_pkg::t_byte         i_data_byte,
    input  logic                     i_end_of_text,
    output logic                     o_valid,
    input  logic                     i_stall,
    output u8dec_pkg::t_code_point   o_code_point,
    output logic                     o_bad_sequence,
    output logic                     o_run_last
);
    import u8dec_pkg::*;

    // input register
    logic        r_in_valid;
    t_byte       r_byte;
    logic        r_eot;

    // decoder state
    t_pend       r_pend;
    t_len        r_len;
    logic        r_lead_ed;
    t_code_point r_partial;

    // result register
    t_res_count  r_cnt;
    logic        r_has_cp;
    t_code_point r_cp;

    t_pend       n_pend;
    t_len        n_len;
    logic        n_lead_ed;
    t_code_point n_partial;
    t_res_count  n_cnt;
    logic        n_has_cp;
    t_code_point n_cp;

    logic        move;
    logic        in_xfer;
    logic        out_xfer;
    logic        cont_byte;
    logic        surrogate;
    logic        broken;
    logic        lead_go;
    t_pend       next_pend;
    t_code_point shifted;

    assign move     = r_in_valid && ((r_cnt == '0) || ((r_cnt == 3'd1) && !i_stall));
    assign o_stall  = r_in_valid && !move;
    assign in_xfer  = i_valid && !o_stall;
    assign o_valid  = (r_cnt != '0);
    assign out_xfer = o_valid && !i_stall;

    assign o_run_last     = (r_cnt == 3'd1);
    assign o_bad_sequence = !((r_cnt == 3'd1) && r_has_cp);
    assign o_code_point   = ((r_cnt == 3'd1) && r_has_cp) ? r_cp : '0;

    assign cont_byte = (r_byte[7:6] == 2'b10);
    assign surrogate = r_lead_ed && (r_pend == 2'd1) && r_byte[7] && r_byte[5];
    assign broken    = (r_pend != '0) && (surrogate || !cont_byte);
    assign lead_go   = (r_pend == '0) || broken;
    assign next_pend = r_pend + 2'd1;
    assign shifted   = {r_partial[CP_W-7:0], r_byte[5:0]};

    always_comb begin
        n_pend    = r_pend;
        n_len     = r_len;
        n_lead_ed = r_lead_ed;
        n_partial = r_partial;
        n_cnt     = '0;
        n_has_cp  = 1'b0;
        n_cp      = '0;

        if (lead_go) begin
            // an interrupted sequence reports one error per byte it took
            if (broken) begin
                n_cnt = {1'b0, r_pend};
            end
            n_pend    = '0;
            n_len     = LEN_NONE;
            n_lead_ed = 1'b0;
            n_partial = '0;
            priority if (!r_byte[7]) begin
                n_cnt    = n_cnt + 3'd1;
                n_has_cp = 1'b1;
                n_cp     = {{(CP_W-BYTE_W){1'b0}}, r_byte};
            end else if (r_byte[7:5] == 3'b110) begin
                n_pend    = 2'd1;
                n_len     = LEN_TWO;
                n_partial = {{(CP_W-5){1'b0}}, r_byte[4:0]};
            end else if (r_byte[7:4] == 4'b1110) begin
                n_pend    = 2'd1;
                n_len     = LEN_THREE;
                n_lead_ed = (r_byte == LEAD_ED);
                n_partial = {{(CP_W-4){1'b0}}, r_byte[3:0]};
            end else if (r_byte[7:3] == 5'b11110) begin
                n_pend    = 2'd1;
                n_len     = LEN_FOUR;
                n_partial = {{(CP_W-3){1'b0}}, r_byte[2:0]};
            end else begin
                n_cnt = n_cnt + 3'd1;
            end
        end else begin
            // count wraps to zero after the fourth byte
            if ((next_pend == '0) || ({1'b0, next_pend} >= r_len)) begin
                n_cnt     = 3'd1;
                n_has_cp  = 1'b1;
                n_cp      = shifted;
                n_pend    = '0;
                n_len     = LEN_NONE;
                n_lead_ed = 1'b0;
                n_partial = '0;
            end else begin
                n_pend    = next_pend;
                n_partial = shifted;
            end
        end

        // cut-off sequence at end of text
        if (r_eot && (n_pend != '0)) begin
            n_cnt     = n_cnt + {1'b0, n_pend};
            n_pend    = '0;
            n_len     = LEN_NONE;
            n_lead_ed = 1'b0;
            n_partial = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pend     <= '0;
            r_len      <= LEN_NONE;
            r_lead_ed  <= 1'b0;
            r_partial  <= '0;
            r_cnt      <= '0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end

            if (move) begin
                r_pend    <= n_pend;
                r_len     <= n_len;
                r_lead_ed <= n_lead_ed;
                r_partial <= n_partial;
                r_cnt     <= n_cnt;
            end else if (out_xfer) begin
                r_cnt <= r_cnt - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_byte <= i_data_byte;
            r_eot  <= i_end_of_text;
        end
        if (move) begin
            r_has_cp <= n_has_cp;
            r_cp     <= n_cp;
        end
    end

endmodule
